[design/lccs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccs_pkg
// Shared constants, command codes and the frame store request type of the
// LED cube chain layer scanner.
// ----------------------------------------------------------------------------
package lccs_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int CHAIN_W = 5;
  localparam int LAYER_W = 2;
  localparam int LED_W   = 16;
  localparam int POS_W   = 2;
  localparam int CODE_W  = 8;
  localparam int WORD_W  = CODE_W + LED_W;

  // Default chain capacity; the store is sized for at most 32 cubes
  localparam int MAX_CUBES_DEF = 25;
  localparam int FS_ADDR_MAX_W = CHAIN_W + LAYER_W;

  // Register file
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam logic [2:0] REG_CHAIN_LEN = 3'd0;
  localparam logic [2:0] REG_CODE_0    = 3'd1;
  localparam logic [2:0] REG_CODE_1    = 3'd2;
  localparam logic [2:0] REG_CODE_2    = 3'd3;
  localparam logic [2:0] REG_CODE_3    = 3'd4;

  // Reset values
  localparam logic [CHAIN_W-1:0] CHAIN_LEN_RST = 5'd1;
  localparam logic [CODE_W-1:0]  CODE_0_RST    = 8'd1;
  localparam logic [CODE_W-1:0]  CODE_1_RST    = 8'd2;
  localparam logic [CODE_W-1:0]  CODE_2_RST    = 8'd4;
  localparam logic [CODE_W-1:0]  CODE_3_RST    = 8'd8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LAYER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LED   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Access request from the sequencer to the frame store
  typedef struct packed {
    logic                     wr_en;
    logic [FS_ADDR_MAX_W-1:0] wr_addr;
    logic [LED_W-1:0]         wr_data;
    logic                     rd_en;
    logic [FS_ADDR_MAX_W-1:0] rd_addr;
    logic                     clr_all;
  } fs_req_t;

endpackage : lccs_pkg
`default_nettype wire

[design/lccs_frame_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccs_frame_store
// One 16-bit LED word per cube layer. Single write port, one registered read
// port; a valid bit per entry makes unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module lccs_frame_store
  import lccs_pkg::*;
#(
  parameter int MAX_CUBES = MAX_CUBES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire fs_req_t          req,
  output logic [LED_W-1:0]      rd_data
);

  localparam int DEPTH  = 4 * MAX_CUBES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [LED_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [LED_W-1:0] rd_data_r;
  logic             rd_vld_r;

  logic [ADDR_W-1:0] wr_idx;
  logic [ADDR_W-1:0] rd_idx;

  assign wr_idx = req.wr_addr[ADDR_W-1:0];
  assign rd_idx = req.rd_addr[ADDR_W-1:0];

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Entry valid bits; clear-all wipes every one of them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clr_all) begin
        vld_r <= '0;
      end else if (req.wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule : lccs_frame_store
`default_nettype wire

[design/led_cube_chain_layer_scanner_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_cube_chain_layer_scanner_core
// Refresh controller for a chain of 4x4x4 LED cubes behind 24-bit shift
// registers.
// ----------------------------------------------------------------------------
// One command word is taken at a time. A scan tick reads the frame store,
// then loads the output register with the first word, then sends
// chain_length + 1 words in all at one per cycle while out_stall is low.
// The output register hands out one word per cycle while out_stall is low,
// which sets the tick length. A layer write or clear-all completes in the
// accept cycle; a single-LED update reads the store, then writes back.
// in_stall is high while a command is in progress.
// Configuration writes must be made only while the block is idle.
// ----------------------------------------------------------------------------
module led_cube_chain_layer_scanner_core
  import lccs_pkg::*;
#(
  parameter int MAX_CUBES = MAX_CUBES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      in_cmd,
  input  wire logic [CHAIN_W-1:0]    in_cube_sel,
  input  wire logic [LAYER_W-1:0]    in_layer_sel,
  input  wire logic [LED_W-1:0]      in_layer_bits,
  input  wire logic [POS_W-1:0]      in_pos_x,
  input  wire logic [POS_W-1:0]      in_pos_y,
  input  wire logic                  in_led_on,
  // shift word channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WORD_W-1:0]          out_shift_word,
  output logic                       out_latch_after,
  output logic                       out_last,
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int DEPTH   = 4 * MAX_CUBES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LAYERS_W = CHAIN_W + 2;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MODIFY = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  // --------------------------------------------------------------------------
  // Register file
  // --------------------------------------------------------------------------
  logic [CHAIN_W-1:0] chain_len_r;
  logic [CODE_W-1:0]  code0_r, code1_r, code2_r, code3_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic [CHAIN_W:0]   chain_req;
  logic [CHAIN_W-1:0] chain_sat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  // saturate the requested chain length into 1..MAX_CUBES
  assign chain_req = {1'b0, pwdata[CHAIN_W-1:0]};
  always_comb begin
    priority if (chain_req == '0) begin
      chain_sat = CHAIN_W'(1);
    end else if (chain_req > (CHAIN_W+1)'(MAX_CUBES)) begin
      chain_sat = CHAIN_W'(MAX_CUBES);
    end else begin
      chain_sat = pwdata[CHAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_len_r <= CHAIN_LEN_RST;
      code0_r     <= CODE_0_RST;
      code1_r     <= CODE_1_RST;
      code2_r     <= CODE_2_RST;
      code3_r     <= CODE_3_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CHAIN_LEN: chain_len_r <= chain_sat;
        REG_CODE_0:    code0_r     <= pwdata[CODE_W-1:0];
        REG_CODE_1:    code1_r     <= pwdata[CODE_W-1:0];
        REG_CODE_2:    code2_r     <= pwdata[CODE_W-1:0];
        REG_CODE_3:    code3_r     <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CHAIN_LEN: prdata = CFG_DATA_W'(chain_len_r);
      REG_CODE_0:    prdata = CFG_DATA_W'(code0_r);
      REG_CODE_1:    prdata = CFG_DATA_W'(code1_r);
      REG_CODE_2:    prdata = CFG_DATA_W'(code2_r);
      REG_CODE_3:    prdata = CFG_DATA_W'(code3_r);
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  logic [1:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [CHAIN_W-1:0] k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;

  // payload registers
  logic [FS_ADDR_MAX_W-1:0] op_addr_r;
  logic [3:0]               op_pos_r;
  logic                     op_on_r;
  logic [CODE_W-1:0]        op_code_r;
  logic [CHAIN_W-1:0]       front_r;
  logic [WORD_W-1:0]        word_r, word_nxt;
  logic                     latch_r, latch_nxt;
  logic                     last_r, last_nxt;

  logic                     accept;
  logic                     in_range;
  logic [FS_ADDR_MAX_W-1:0] sel_addr;
  logic [LAYERS_W-1:0]      layers;
  logic [ADDR_W-1:0]        scan_eff;
  logic [LAYERS_W:0]        scan_inc;
  logic [CODE_W-1:0]        cur_code;
  logic [LED_W-1:0]         rd_data;
  logic [LED_W-1:0]         led_mask;
  logic [LED_W-1:0]         led_word;
  fs_req_t                  fs_req;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign in_range = (in_cube_sel < chain_len_r);
  assign sel_addr = {in_cube_sel, in_layer_sel};

  // scan index wrap, including a stale index left by a shortened chain
  assign layers   = {chain_len_r, 2'b00};
  assign scan_eff = (LAYERS_W'(scan_idx_r) >= layers) ? '0 : scan_idx_r;
  assign scan_inc = (LAYERS_W+1)'(scan_eff) + (LAYERS_W+1)'(1);

  always_comb begin
    unique case (phase_r)
      2'd0:    cur_code = code0_r;
      2'd1:    cur_code = code1_r;
      2'd2:    cur_code = code2_r;
      default: cur_code = code3_r;
    endcase
  end

  // single-LED read-modify-write
  assign led_mask = LED_W'(1) << op_pos_r;
  assign led_word = op_on_r ? (rd_data | led_mask) : (rd_data & ~led_mask);

  // next-state and store requests
  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    phase_nxt     = phase_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    word_nxt      = word_r;
    latch_nxt     = latch_r;
    last_nxt      = last_r;
    fs_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_LAYER: begin
              if (in_range) begin
                fs_req.wr_en   = 1'b1;
                fs_req.wr_addr = sel_addr;
                fs_req.wr_data = in_layer_bits;
              end
            end
            CMD_LED: begin
              if (in_range) begin
                fs_req.rd_en   = 1'b1;
                fs_req.rd_addr = sel_addr;
                state_nxt      = ST_MODIFY;
              end
            end
            CMD_CLEAR: begin
              fs_req.clr_all = 1'b1;
            end
            default: begin
              fs_req.rd_en   = 1'b1;
              fs_req.rd_addr = FS_ADDR_MAX_W'(scan_eff);
              phase_nxt      = phase_r + 2'd1;
              scan_idx_nxt   = (scan_inc >= (LAYERS_W+1)'(layers)) ? '0
                                                                    : ADDR_W'(scan_inc);
              state_nxt      = ST_LOAD;
            end
          endcase
        end
      end
      ST_MODIFY: begin
        fs_req.wr_en   = 1'b1;
        fs_req.wr_addr = op_addr_r;
        fs_req.wr_data = led_word;
        state_nxt      = ST_IDLE;
      end
      ST_LOAD: begin
        // first word carries the layer code and the LED bits
        out_valid_nxt = 1'b1;
        word_nxt      = {op_code_r, rd_data};
        latch_nxt     = (front_r == '0);
        last_nxt      = 1'b0;
        k_nxt         = '0;
        state_nxt     = ST_EMIT;
      end
      default: begin
        // padding words until the chain is filled
        if (!out_stall) begin
          if (k_r == chain_len_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            k_nxt     = k_r + CHAIN_W'(1);
            word_nxt  = '0;
            latch_nxt = (front_r == k_r + CHAIN_W'(1));
            last_nxt  = (chain_len_r == k_r + CHAIN_W'(1));
          end
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      phase_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    latch_r <= latch_nxt;
    last_r  <= last_nxt;
    if (accept) begin
      op_addr_r <= sel_addr;
      op_pos_r  <= {in_pos_y, in_pos_x};
      op_on_r   <= in_led_on;
      op_code_r <= cur_code;
      front_r   <= CHAIN_W'(scan_eff >> 2);
    end
  end

  lccs_frame_store #(
    .MAX_CUBES (MAX_CUBES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (fs_req),
    .rd_data (rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_shift_word  = word_r;
  assign out_latch_after = latch_r;
  assign out_last        = last_r;

endmodule : led_cube_chain_layer_scanner_core
`default_nettype wire

[design/lccs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccs_checker
// Port-level checks of the scanner: word ordering within a tick and the
// relation between the command and result channels.
// ----------------------------------------------------------------------------
module lccs_checker
  import lccs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [CMD_W-1:0]  in_cmd,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [WORD_W-1:0] out_shift_word,
  input wire logic              out_latch_after,
  input wire logic              out_last
);

  // no new command while words of a tick are pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("command accepted while tick words pending");

  // a non-tick command produces no word
  a_no_word_for_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd != CMD_TICK) |=> !out_valid)
    else $error("word produced by a non-tick command");

  // the final word of a tick ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("word follows the final word of a tick");

  // a word with the latch marker is not directly followed by another one
  a_one_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_latch_after) |=> !(out_valid && out_latch_after))
    else $error("second latch marker within a tick");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_shift_word)))
    else $error("stalled word changed");

endmodule : lccs_checker

bind led_cube_chain_layer_scanner_core lccs_checker u_lccs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_shift_word  (out_shift_word),
  .out_latch_after (out_latch_after),
  .out_last        (out_last)
);
`default_nettype wire
